/* design/snpid_pkg.sv */
// Shared types, constants and saturation helpers for the single-neuron PID core.
// No dependencies; used by snpid_div and single_neuron_adaptive_pid_core.
`timescale 1ns / 1ps
package snpid_pkg;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // divider geometry: 64-bit magnitude over a 34-bit weight sum, 32-bit quotient
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 34;
    localparam int DIV_QW = 32;
    localparam int DIV_CW = $clog2(DIV_QW);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_P = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_I = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_D = 3'd6;

    // multiply steps of one control item
    typedef logic [3:0] op_t;
    localparam op_t OP_WI_ERR  = 4'd0;
    localparam op_t OP_WP_D1   = 4'd1;
    localparam op_t OP_WD_D2   = 4'd2;
    localparam op_t OP_GAIN    = 4'd3;
    localparam op_t OP_ERR_DRV = 4'd4;
    localparam op_t OP_A_ERR   = 4'd5;
    localparam op_t OP_A_D1    = 4'd6;
    localparam op_t OP_A_D2    = 4'd7;
    localparam op_t OP_RATE_I  = 4'd8;
    localparam op_t OP_RATE_P  = 4'd9;
    localparam op_t OP_RATE_D  = 4'd10;

    localparam logic [31:0] WEIGHT_RESET = 32'd1677722;
    localparam logic [15:0] GAIN_RESET   = 16'd2048;
    localparam logic [15:0] RATE_P_RESET = 16'd3482;
    localparam logic [15:0] RATE_I_RESET = 16'd0;
    localparam logic [15:0] RATE_D_RESET = 16'd1024;

    localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
    localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

    function automatic logic ovf32(input logic signed [49:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [49:0] sx50(input logic signed [31:0] v);
        return {{18{v[31]}}, v};
    endfunction

endpackage

/* design/single_neuron_adaptive_pid_core.sv */
// Single-neuron adaptive PID: one shared 33x33 multiplier and a serial divider.
// Control item: prep, 11 multiplies with the divide after the third, then done.
// Zero weight sum skips the divider. Reinitialize item: prep, then done.
// One item at a time; the output register lets the next item in while a result waits.
// aresetn (synchronous, low) restores gain/rates/init registers, weights and history.
`timescale 1ns / 1ps
module single_neuron_adaptive_pid_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [snpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic [15:0]                       s_target,
    input  logic signed [31:0]                s_measured,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [31:0]                m_drive,
    output logic                              m_weights_zero,
    output logic                              m_saturated
);
    import snpid_pkg::*;

    // configuration
    logic [15:0]        gain_reg, rate_p_reg, rate_i_reg, rate_d_reg;
    logic signed [31:0] init_p_reg, init_i_reg, init_d_reg;

    // controller state
    logic signed [31:0] prev_err_reg, prev_err_next;
    logic signed [31:0] old_err_reg, old_err_next;
    logic signed [31:0] acc_drv_reg, acc_drv_next;
    logic signed [31:0] wp_reg, wp_next, wi_reg, wi_next, wd_reg, wd_next;

    // sequencer and working registers
    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic               phase_reg, phase_next;
    logic               mode_reg, mode_next;
    logic [15:0]        target_reg, target_next;
    logic signed [31:0] meas_reg, meas_next;
    logic signed [31:0] err_reg, err_next, d1_reg, d1_next, d2_reg, d2_next;
    logic [33:0]        sum_reg, sum_next;
    logic signed [65:0] acc_reg, acc_next;
    logic [31:0]        q_reg, q_next;
    logic signed [31:0] a_reg, a_next;
    logic signed [31:0] bi_reg, bi_next, bp_reg, bp_next, bd_reg, bd_next;
    logic               clip_reg, clip_next, zero_reg, zero_next;
    logic signed [65:0] prod_reg;

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_drive_reg, m_drive_next;
    logic               m_zero_reg, m_zero_next, m_sat_reg, m_sat_next;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    // divider
    logic               div_start, div_done;
    logic [DIV_QW-1:0]  div_quot;
    logic [65:0]        acc_mag;

    // datapath temporaries
    logic signed [49:0] tgt50, e50, d150, d250, drv50, inc50, wsum50;
    logic signed [31:0] err_c;
    logic [32:0]        abs_p, abs_i, abs_d;
    logic signed [65:0] p16_bias, p16, p4_bias, p4;
    logic [35:0]        m_mag;
    logic signed [31:0] w_sel;

    logic s_fire;
    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= GAIN_RESET;
            rate_p_reg <= RATE_P_RESET;
            rate_i_reg <= RATE_I_RESET;
            rate_d_reg <= RATE_D_RESET;
            init_p_reg <= WEIGHT_RESET;
            init_i_reg <= WEIGHT_RESET;
            init_d_reg <= WEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg   <= cfg_data[15:0];
                REG_RATE_P: rate_p_reg <= cfg_data[15:0];
                REG_RATE_I: rate_i_reg <= cfg_data[15:0];
                REG_RATE_D: rate_d_reg <= cfg_data[15:0];
                REG_INIT_P: init_p_reg <= cfg_data;
                REG_INIT_I: init_i_reg <= cfg_data;
                REG_INIT_D: init_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        case (op_reg)
            OP_WI_ERR:  begin mul_a = {wi_reg[31], wi_reg}; mul_b = {err_reg[31], err_reg}; end
            OP_WP_D1:   begin mul_a = {wp_reg[31], wp_reg}; mul_b = {d1_reg[31], d1_reg}; end
            OP_WD_D2:   begin mul_a = {wd_reg[31], wd_reg}; mul_b = {d2_reg[31], d2_reg}; end
            OP_GAIN:    begin mul_a = {1'b0, q_reg}; mul_b = {17'b0, gain_reg}; end
            OP_ERR_DRV: begin
                mul_a = {err_reg[31], err_reg};
                mul_b = {acc_drv_reg[31], acc_drv_reg};
            end
            OP_A_ERR:   begin mul_a = {a_reg[31], a_reg}; mul_b = {err_reg[31], err_reg}; end
            OP_A_D1:    begin mul_a = {a_reg[31], a_reg}; mul_b = {d1_reg[31], d1_reg}; end
            OP_A_D2:    begin mul_a = {a_reg[31], a_reg}; mul_b = {d2_reg[31], d2_reg}; end
            OP_RATE_I:  begin mul_a = {bi_reg[31], bi_reg}; mul_b = {17'b0, rate_i_reg}; end
            OP_RATE_P:  begin mul_a = {bp_reg[31], bp_reg}; mul_b = {17'b0, rate_p_reg}; end
            OP_RATE_D:  begin mul_a = {bd_reg[31], bd_reg}; mul_b = {17'b0, rate_d_reg}; end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // divider on the magnitude of the weighted sum
    assign acc_mag   = acc_reg[65] ? 66'(-acc_reg) : acc_reg;
    assign div_start = (state_reg == ST_DIV) && !phase_reg;

    snpid_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_mag[DIV_NW-1:0]),
        .den     (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // product post-processing: truncation toward zero by 2^16, 2^12 and 2^4
    always_comb begin
        p16_bias = prod_reg + (prod_reg[65] ? 66'sd65535 : 66'sd0);
        p16      = p16_bias >>> 16;
        p4_bias  = prod_reg + (prod_reg[65] ? 66'sd15 : 66'sd0);
        p4       = p4_bias >>> 4;
        m_mag    = prod_reg[47:12];
        inc50    = acc_reg[65] ? -$signed({14'b0, m_mag}) : $signed({14'b0, m_mag});
        drv50    = sx50(acc_drv_reg) + inc50;
        case (op_reg)
            OP_RATE_I: w_sel = wi_reg;
            OP_RATE_P: w_sel = wp_reg;
            default:   w_sel = wd_reg;
        endcase
        wsum50   = sx50(w_sel) + p4[49:0];
    end

    // error and differences
    always_comb begin
        tgt50 = $signed({18'b0, target_reg, 16'b0});
        e50   = tgt50 - sx50(meas_reg);
        err_c = sat32(e50);
        d150  = sx50(err_c) - sx50(prev_err_reg);
        d250  = sx50(err_c) - (sx50(prev_err_reg) <<< 1) + sx50(old_err_reg);
        abs_p = wp_reg[31] ? 33'(-$signed({wp_reg[31], wp_reg})) : {1'b0, wp_reg};
        abs_i = wi_reg[31] ? 33'(-$signed({wi_reg[31], wi_reg})) : {1'b0, wi_reg};
        abs_d = wd_reg[31] ? 33'(-$signed({wd_reg[31], wd_reg})) : {1'b0, wd_reg};
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        phase_next    = phase_reg;
        mode_next     = mode_reg;
        target_next   = target_reg;
        meas_next     = meas_reg;
        err_next      = err_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        sum_next      = sum_reg;
        acc_next      = acc_reg;
        q_next        = q_reg;
        a_next        = a_reg;
        bi_next       = bi_reg;
        bp_next       = bp_reg;
        bd_next       = bd_reg;
        clip_next     = clip_reg;
        zero_next     = zero_reg;
        prev_err_next = prev_err_reg;
        old_err_next  = old_err_reg;
        acc_drv_next  = acc_drv_reg;
        wp_next       = wp_reg;
        wi_next       = wi_reg;
        wd_next       = wd_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_drive_next  = m_drive_reg;
        m_zero_next   = m_zero_reg;
        m_sat_next    = m_sat_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    mode_next   = s_mode;
                    target_next = s_target;
                    meas_next   = s_measured;
                    clip_next   = 1'b0;
                    zero_next   = 1'b0;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP: begin
                if (mode_reg) begin
                    wp_next       = init_p_reg;
                    wi_next       = init_i_reg;
                    wd_next       = init_d_reg;
                    prev_err_next = '0;
                    old_err_next  = '0;
                    acc_drv_next  = '0;
                    state_next    = ST_DONE;
                end else begin
                    err_next   = err_c;
                    d1_next    = sat32(d150);
                    d2_next    = sat32(d250);
                    clip_next  = ovf32(e50) || ovf32(d150) || ovf32(d250);
                    sum_next   = {1'b0, abs_p} + {1'b0, abs_i} + {1'b0, abs_d};
                    acc_next   = '0;
                    op_next    = OP_WI_ERR;
                    phase_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    op_next = op_reg + 1'b1;
                    case (op_reg) inside
                        OP_WI_ERR, OP_WP_D1: acc_next = acc_reg + prod_reg;
                        OP_WD_D2: begin
                            acc_next = acc_reg + prod_reg;
                            if (sum_reg == '0) begin
                                // no divide: increment becomes zero
                                zero_next = 1'b1;
                                q_next    = '0;
                            end else begin
                                state_next = ST_DIV;
                            end
                        end
                        OP_GAIN: begin
                            acc_drv_next = sat32(drv50);
                            clip_next    = clip_reg || ovf32(drv50);
                        end
                        OP_ERR_DRV: begin
                            a_next    = sat32(p16[49:0]);
                            clip_next = clip_reg || ovf32(p16[49:0]);
                        end
                        OP_A_ERR, OP_A_D1, OP_A_D2: begin
                            if (op_reg == OP_A_ERR) bi_next = sat32(p16[49:0]);
                            if (op_reg == OP_A_D1)  bp_next = sat32(p16[49:0]);
                            if (op_reg == OP_A_D2)  bd_next = sat32(p16[49:0]);
                            clip_next = clip_reg || ovf32(p16[49:0]);
                        end
                        OP_RATE_I, OP_RATE_P, OP_RATE_D: begin
                            if (op_reg == OP_RATE_I) wi_next = sat32(wsum50);
                            if (op_reg == OP_RATE_P) wp_next = sat32(wsum50);
                            if (op_reg == OP_RATE_D) begin
                                wd_next    = sat32(wsum50);
                                state_next = ST_DONE;
                            end
                            clip_next = clip_reg || ovf32(wsum50);
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                phase_next = 1'b1;
                if (div_done) begin
                    q_next     = div_quot;
                    op_next    = OP_GAIN;
                    phase_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_drive_next = acc_drv_reg;
                    m_zero_next  = zero_reg;
                    m_sat_next   = clip_reg;
                    if (!mode_reg) begin
                        old_err_next  = prev_err_reg;
                        prev_err_next = err_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        phase_reg   <= phase_next;
        mode_reg    <= mode_next;
        target_reg  <= target_next;
        meas_reg    <= meas_next;
        err_reg     <= err_next;
        d1_reg      <= d1_next;
        d2_reg      <= d2_next;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
        q_reg       <= q_next;
        a_reg       <= a_next;
        bi_reg      <= bi_next;
        bp_reg      <= bp_next;
        bd_reg      <= bd_next;
        clip_reg    <= clip_next;
        zero_reg    <= zero_next;
        m_drive_reg <= m_drive_next;
        m_zero_reg  <= m_zero_next;
        m_sat_reg   <= m_sat_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            prev_err_reg <= '0;
            old_err_reg  <= '0;
            acc_drv_reg  <= '0;
            wp_reg       <= WEIGHT_RESET;
            wi_reg       <= WEIGHT_RESET;
            wd_reg       <= WEIGHT_RESET;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            prev_err_reg <= prev_err_next;
            old_err_reg  <= old_err_next;
            acc_drv_reg  <= acc_drv_next;
            wp_reg       <= wp_next;
            wi_reg       <= wi_next;
            wd_reg       <= wd_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_drive        = m_drive_reg;
    assign m_weights_zero = m_zero_reg;
    assign m_saturated    = m_sat_reg;

    // divider only finishes while the sequencer waits for it
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide state");

    // op index stays within the multiply schedule
    a_op_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (op_reg <= OP_RATE_D))
        else $error("multiply step out of range");

    // a reinitialize item always reports a cleared drive
    a_reinit_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && mode_reg) |-> (acc_drv_reg == '0 && !clip_reg && !zero_reg))
        else $error("reinitialize result not cleared");

    // zero weight sum never starts the divider
    a_zero_no_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (sum_reg != '0))
        else $error("divide started on zero weight sum");

endmodule

/* design/snpid_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on snpid_pkg for its widths.
`timescale 1ns / 1ps
module snpid_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [snpid_pkg::DIV_NW-1:0]   num,
    input  logic [snpid_pkg::DIV_DW-1:0]   den,
    output logic                           done,
    output logic [snpid_pkg::DIV_QW-1:0]   quot
);
    import snpid_pkg::*;

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_QW-1:0] ql_reg, ql_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   trial;
    logic              ge;

    // quotient fits in 32 bits, so the upper numerator half starts below den
    always_comb begin
        trial     = {rem_reg, ql_reg[DIV_QW-1]};
        ge        = trial >= {1'b0, den};
        rem_next  = rem_reg;
        ql_next   = ql_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = {{(DIV_DW-DIV_QW){1'b0}}, num[DIV_NW-1:DIV_QW]};
            ql_next   = num[DIV_QW-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? DIV_DW'(trial - {1'b0, den}) : trial[DIV_DW-1:0];
            ql_next  = {ql_reg[DIV_QW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        ql_reg  <= ql_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = ql_reg;

endmodule

/* dv/snpid_checker.sv */
// Drive predictor and result checker for the single-neuron PID core.
// Watches the config port and both channels; depends on snpid_pkg for register indexes.
`timescale 1ns / 1ps
module snpid_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [snpid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_mode,
    input  logic [15:0]                     s_target,
    input  logic signed [31:0]              s_measured,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic signed [31:0]              m_drive,
    input  logic                            m_weights_zero,
    input  logic                            m_saturated,
    output int                              fail_count,
    output int                              pending,
    output int                              results_checked
);
    import snpid_pkg::*;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               weights_zero;
        logic               saturated;
    } drive_result_t;

    drive_result_t expected_drives[$];

    logic [15:0] gain_q, rate_p_q, rate_i_q, rate_d_q;
    longint      init_p, init_i, init_d;
    longint      err_prev, err_older, drive_acc, w_p, w_i, w_d;

    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Hebbian update of one weight from its input x
    function automatic longint hebb_update(input longint w, input logic [15:0] rate,
                                           input longint e, input longint drv,
                                           input longint x, inout bit clipped);
        longint a, b, c;
        a = clip32((e * drv) / 65536, clipped);
        b = clip32((a * x) / 65536, clipped);
        c = (b * longint'(rate)) / 16;
        return clip32(w + c, clipped);
    endfunction

    function automatic drive_result_t predict_drive(input logic mode, input logic [15:0] tgt,
                                                    input logic signed [31:0] meas);
        drive_result_t      r;
        bit                 clipped;
        longint             e, d1, d2, drv, inc;
        logic [33:0]        wsum;
        logic signed [66:0] num;
        logic [66:0]        mag, quo;
        clipped = 1'b0;
        inc = 0;
        if (mode) begin
            w_p = init_p;
            w_i = init_i;
            w_d = init_d;
            err_prev = 0;
            err_older = 0;
            drive_acc = 0;
            r.drive = '0;
            r.weights_zero = 1'b0;
            r.saturated = 1'b0;
            return r;
        end
        e  = clip32(longint'(tgt) * 65536 - longint'(meas), clipped);
        d1 = clip32(e - err_prev, clipped);
        d2 = clip32(e - 2 * err_prev + err_older, clipped);
        wsum = 34'((w_i < 0) ? -w_i : w_i) + 34'((w_p < 0) ? -w_p : w_p)
             + 34'((w_d < 0) ? -w_d : w_d);
        r.weights_zero = (wsum == 0);
        if (wsum != 0) begin
            num = w_i * e;
            num = num + w_p * d1;
            num = num + w_d * d2;
            mag = (num < 0) ? 67'(-num) : 67'(num);
            quo = mag / wsum;
            quo = (quo * gain_q) >> 12;
            inc = (num < 0) ? -longint'(quo) : longint'(quo);
        end
        drv = clip32(drive_acc + inc, clipped);
        drive_acc = drv;
        w_i = hebb_update(w_i, rate_i_q, e, drv, e, clipped);
        w_p = hebb_update(w_p, rate_p_q, e, drv, d1, clipped);
        w_d = hebb_update(w_d, rate_d_q, e, drv, d2, clipped);
        err_older = err_prev;
        err_prev = e;
        r.drive = drv[31:0];
        r.saturated = clipped;
        return r;
    endfunction

    always @(posedge aclk) begin
        drive_result_t want;
        if (!aresetn) begin
            gain_q   = GAIN_RESET;
            rate_p_q = RATE_P_RESET;
            rate_i_q = RATE_I_RESET;
            rate_d_q = RATE_D_RESET;
            init_p = longint'(signed'(WEIGHT_RESET));
            init_i = init_p;
            init_d = init_p;
            w_p = init_p;
            w_i = init_p;
            w_d = init_p;
            err_prev = 0;
            err_older = 0;
            drive_acc = 0;
            expected_drives.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GAIN:   gain_q   = cfg_data[15:0];
                    REG_RATE_P: rate_p_q = cfg_data[15:0];
                    REG_RATE_I: rate_i_q = cfg_data[15:0];
                    REG_RATE_D: rate_d_q = cfg_data[15:0];
                    REG_INIT_P: init_p = longint'(signed'(cfg_data));
                    REG_INIT_I: init_i = longint'(signed'(cfg_data));
                    REG_INIT_D: init_d = longint'(signed'(cfg_data));
                    default: ;
                endcase
            end
            // result first: it can never belong to an item accepted on the same edge
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_drives.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%t: result transfer with nothing expected, drive %0d",
                                 $realtime, m_drive);
                end else begin
                    want = expected_drives.pop_front();
                    if (want.drive !== m_drive || want.weights_zero !== m_weights_zero
                            || want.saturated !== m_saturated) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%t: mismatch exp drive %0d wz %0b sat %0b, got %0d %0b %0b",
                                     $realtime, want.drive, want.weights_zero, want.saturated,
                                     m_drive, m_weights_zero, m_saturated);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_drives.push_back(predict_drive(s_mode, s_target, s_measured));
        end
        pending <= expected_drives.size();
    end
endmodule

/* dv/tb_single_neuron_adaptive_pid_core.sv */
// Top of the single-neuron PID core testbench: clock, reset, config and item stimulus.
// Depends on snpid_pkg, the core and snpid_checker, which predicts and compares results.
`timescale 1ns / 1ps
module tb_single_neuron_adaptive_pid_core;
    import snpid_pkg::*;

    localparam int STALL_LIMIT = 50000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_mode = 1'b0;
    logic [15:0]          s_target = '0;
    logic signed [31:0]   s_measured = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [31:0]   m_drive;
    logic                 m_weights_zero;
    logic                 m_saturated;

    int fail_count, pending, results_checked;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    single_neuron_adaptive_pid_core u_top (.*);

    snpid_checker u_checker (.*);

    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // called right after a rising edge; returns right after the edge of the transfer
    task automatic send_item(input logic mode, input logic [15:0] tgt,
                             input logic [31:0] meas);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= mode;
        s_target   <= tgt;
        s_measured <= meas;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [15:0] gain, input logic [15:0] rp,
                                 input logic [15:0] ri, input logic [15:0] rd,
                                 input logic [31:0] wp, input logic [31:0] wi,
                                 input logic [31:0] wd);
        write_reg(REG_GAIN, gain);
        write_reg(REG_RATE_P, rp);
        write_reg(REG_RATE_I, ri);
        write_reg(REG_RATE_D, rd);
        write_reg(REG_INIT_P, wp);
        write_reg(REG_INIT_I, wi);
        write_reg(REG_INIT_D, wd);
        cfg_wr_en <= 1'b0;
        send_item(1'b1, '0, '0);  // reload weights from the new init values
    endtask

    // mostly tracking steps near the setpoint, some wide and extreme ones, occasional reinitialize items
    task automatic random_step();
        logic [15:0] tgt;
        logic [31:0] meas;
        if ($urandom_range(99) < 4) begin
            send_item(1'b1, 16'($urandom), $urandom);
            return;
        end
        tgt = ($urandom_range(9) < 7) ? 16'($urandom_range(3000)) : 16'($urandom);
        case ($urandom_range(9)) inside
            [0:5]:   meas = {tgt, 16'h0} + 32'($urandom_range(2097152)) - 32'd1048576;
            6, 7:    meas = $urandom;
            8:       meas = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            default: meas = {16'($urandom_range(3000)), 16'($urandom)};
        endcase
        send_item(1'b0, tgt, meas);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset settings, field extremes, error saturation both ways
        send_item(1'b0, 16'd0, 32'd0);
        send_item(1'b0, 16'd100, 32'd0);
        send_item(1'b0, 16'd100, 32'h00640000);
        send_item(1'b0, 16'hFFFF, 32'h80000000);
        send_item(1'b0, 16'd0, 32'h7FFFFFFF);
        send_item(1'b0, 16'd32768, 32'd0);
        send_item(1'b0, 16'd0, 32'hFFFFFFFF);
        send_item(1'b1, 16'hFFFF, 32'hFFFFFFFF);
        send_item(1'b0, 16'd50, 32'h00100000);
        drain_results();
        // zero weight sum
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0, 32'd0, 32'd0);
        send_item(1'b0, 16'd10, 32'd0);
        send_item(1'b0, 16'd20, 32'h00050000);
        send_item(1'b0, 16'hFFFF, 32'h80000000);
        drain_results();
        // extreme weights and rates
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_item(1'b0, 16'd300, 32'd0);
        send_item(1'b0, 16'd0, 32'h01000000);
        send_item(1'b0, 16'd5, 32'h00020000);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            case (ph)
                0: load_settings(GAIN_RESET, RATE_P_RESET, RATE_I_RESET, RATE_D_RESET,
                                 WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET);
                1: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 32'd1, 32'hFFFFFFFF, 32'd0);
                2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
                default: load_settings(16'($urandom), 16'($urandom_range(8192)),
                                       16'($urandom_range(8192)), 16'($urandom_range(8192)),
                                       $urandom, $urandom, $urandom);
            endcase
            for (int k = 0; k < 205; k++) begin
                random_step();
                // hold-off: let every outstanding result come back mid-phase
                if (k == 100) drain_results();
            end
            drain_results();
        end

        $display("Sent %0d items over directed cases and 8 register settings; %0d results checked",
                 items_sent, results_checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/snpid_pkg.sv
design/snpid_div.sv
design/single_neuron_adaptive_pid_core.sv
dv/snpid_checker.sv
dv/tb_single_neuron_adaptive_pid_core.sv
